// File: rtl/psi_pkg.sv
// Shared types, codes and helpers for the payload safety interlock.
`timescale 1ns / 1ps
`default_nettype none
package psi_pkg;

    localparam int unsigned FUNC_W   = 3;
    localparam int unsigned ALT_W    = 16;
    localparam int unsigned WIND_W   = 10;
    localparam int unsigned TMO_W    = 16;
    localparam int unsigned MAXALT_W = 15;
    localparam int unsigned MODE_W   = 3;
    localparam int unsigned REASON_W = 2;
    localparam int unsigned COUNT_W  = 32;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_TICK   = 3'd0,
        FUNC_UPDATE = 3'd1,
        FUNC_ARM    = 3'd2,
        FUNC_RUN    = 3'd3,
        FUNC_STOP   = 3'd4,
        FUNC_DROP   = 3'd5,
        FUNC_PULSE  = 3'd6
    } t_func;

    typedef enum logic [4:0] {
        ST_IDLE      = 5'b00001,
        ST_ARMED     = 5'b00010,
        ST_RUNNING   = 5'b00100,
        ST_RELEASED  = 5'b01000,
        ST_INHIBITED = 5'b10000
    } t_mode;

    localparam logic [MODE_W-1:0] MODE_IDLE      = 3'd0;
    localparam logic [MODE_W-1:0] MODE_ARMED     = 3'd1;
    localparam logic [MODE_W-1:0] MODE_RUNNING   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_RELEASED  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_INHIBITED = 3'd4;

    typedef enum logic [REASON_W-1:0] {
        REASON_NONE     = 2'd0,
        REASON_LINK     = 2'd1,
        REASON_ALTITUDE = 2'd2,
        REASON_WIND     = 2'd3
    } t_reason;

    localparam logic [CFG_IDX_W-1:0] CFG_LINK_TIMEOUT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ALTITUDE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_WIND     = 2'd2;

    localparam logic [TMO_W-1:0]    LINK_TIMEOUT_RST = 16'd1000;
    localparam logic [MAXALT_W-1:0] MAX_ALTITUDE_RST = 15'd50;
    localparam logic [WIND_W-1:0]   MAX_WIND_RST     = 10'd50;

    typedef struct packed {
        logic [TMO_W-1:0]    link_timeout_ticks;
        logic [MAXALT_W-1:0] max_altitude_dm;
        logic [WIND_W-1:0]   max_wind_dmps;
    } t_cfg;

    typedef struct packed {
        logic [MODE_W-1:0]   mode;
        logic                pump_on;
        logic                cargo_released;
        logic                inhibit_event;
        logic [REASON_W-1:0] breach_reason;
        logic [COUNT_W-1:0]  pulse_total;
    } t_result;

    function automatic logic [MODE_W-1:0] mode_code(input t_mode m);
        logic [MODE_W-1:0] c;
        unique case (m)
            ST_IDLE:      c = MODE_IDLE;
            ST_ARMED:     c = MODE_ARMED;
            ST_RUNNING:   c = MODE_RUNNING;
            ST_RELEASED:  c = MODE_RELEASED;
            ST_INHIBITED: c = MODE_INHIBITED;
            default:      c = MODE_IDLE;
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

// File: rtl/psi_envelope.sv
// Safety envelope check: link age, altitude and wind against their limits.
`timescale 1ns / 1ps
`default_nettype none
module psi_envelope (
    input  var psi_pkg::t_cfg                     i_cfg,
    input  wire logic [psi_pkg::TMO_W-1:0]        i_link_age,
    input  wire logic signed [psi_pkg::ALT_W-1:0] i_altitude,
    input  wire logic [psi_pkg::WIND_W-1:0]       i_wind,
    output var psi_pkg::t_reason                  o_reason
);

    logic signed [psi_pkg::ALT_W-1:0] max_alt_s;
    logic link_bad;
    logic alt_bad;
    logic wind_bad;

    assign max_alt_s = $signed({1'b0, i_cfg.max_altitude_dm});
    assign link_bad  = i_link_age > i_cfg.link_timeout_ticks;
    assign alt_bad   = i_altitude > max_alt_s;
    assign wind_bad  = i_wind > i_cfg.max_wind_dmps;

    always_comb begin
        priority if (link_bad) begin
            o_reason = psi_pkg::REASON_LINK;
        end else if (alt_bad) begin
            o_reason = psi_pkg::REASON_ALTITUDE;
        end else if (wind_bad) begin
            o_reason = psi_pkg::REASON_WIND;
        end else begin
            o_reason = psi_pkg::REASON_NONE;
        end
    end

endmodule
`default_nettype wire

// File: rtl/psi_core.sv
// Interlock state registers, event decode and next-result logic.
`timescale 1ns / 1ps
`default_nettype none
module psi_core (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_advance,
    input  wire logic [psi_pkg::FUNC_W-1:0]        i_func,
    input  wire logic signed [psi_pkg::ALT_W-1:0]  i_altitude_dm,
    input  wire logic [psi_pkg::WIND_W-1:0]        i_wind_dmps,
    input  var psi_pkg::t_cfg                      i_cfg,
    output var psi_pkg::t_result                   o_result
);

    psi_pkg::t_mode                    r_mode, n_mode, mode_mid;
    logic signed [psi_pkg::ALT_W-1:0]  r_last_alt, n_last_alt;
    logic [psi_pkg::WIND_W-1:0]        r_last_wind, n_last_wind;
    logic [psi_pkg::TMO_W-1:0]         r_link_age, n_link_age;
    logic [psi_pkg::COUNT_W-1:0]       r_pulse_count, n_pulse_count;
    logic                              r_released, n_released;
    logic                              event_inh;
    psi_pkg::t_reason                  reason;
    logic                              active;

    assign active = (r_mode == psi_pkg::ST_ARMED) || (r_mode == psi_pkg::ST_RUNNING);

    always_comb begin
        mode_mid      = r_mode;
        n_last_alt    = r_last_alt;
        n_last_wind   = r_last_wind;
        n_link_age    = r_link_age;
        n_pulse_count = r_pulse_count;
        n_released    = r_released;
        unique case (psi_pkg::t_func'(i_func))
            psi_pkg::FUNC_TICK: begin
                if (r_link_age != '1) begin
                    n_link_age = r_link_age + 1'b1;
                end
            end
            psi_pkg::FUNC_UPDATE: begin
                n_last_alt  = i_altitude_dm;
                n_last_wind = i_wind_dmps;
                n_link_age  = '0;
            end
            psi_pkg::FUNC_ARM: begin
                mode_mid      = psi_pkg::ST_ARMED;
                n_pulse_count = '0;
            end
            psi_pkg::FUNC_RUN: begin
                if (active) begin
                    mode_mid = psi_pkg::ST_RUNNING;
                end
            end
            psi_pkg::FUNC_STOP: begin
                if (r_mode == psi_pkg::ST_RUNNING) begin
                    mode_mid = psi_pkg::ST_ARMED;
                end
            end
            psi_pkg::FUNC_DROP: begin
                if (active) begin
                    mode_mid   = psi_pkg::ST_RELEASED;
                    n_released = 1'b1;
                end
            end
            psi_pkg::FUNC_PULSE: begin
                n_pulse_count = r_pulse_count + 1'b1;
            end
            default: begin
            end
        endcase
    end

    psi_envelope u_envelope (
        .i_cfg      (i_cfg),
        .i_link_age (n_link_age),
        .i_altitude (n_last_alt),
        .i_wind     (n_last_wind),
        .o_reason   (reason)
    );

    always_comb begin
        n_mode    = mode_mid;
        event_inh = 1'b0;
        if (reason != psi_pkg::REASON_NONE) begin
            if ((mode_mid == psi_pkg::ST_ARMED) || (mode_mid == psi_pkg::ST_RUNNING)) begin
                n_mode    = psi_pkg::ST_INHIBITED;
                event_inh = 1'b1;
            end
        end else if (mode_mid == psi_pkg::ST_INHIBITED) begin
            n_mode = psi_pkg::ST_ARMED;
        end
    end

    always_comb begin
        o_result.mode           = psi_pkg::mode_code(n_mode);
        o_result.pump_on        = (n_mode == psi_pkg::ST_RUNNING);
        o_result.cargo_released = n_released;
        o_result.inhibit_event  = event_inh;
        o_result.breach_reason  = reason;
        o_result.pulse_total    = n_pulse_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= psi_pkg::ST_IDLE;
            r_last_alt    <= '0;
            r_last_wind   <= '0;
            r_link_age    <= '0;
            r_pulse_count <= '0;
            r_released    <= 1'b0;
        end else if (i_advance) begin
            r_mode        <= n_mode;
            r_last_alt    <= n_last_alt;
            r_last_wind   <= n_last_wind;
            r_link_age    <= n_link_age;
            r_pulse_count <= n_pulse_count;
            r_released    <= n_released;
        end
    end

endmodule
`default_nettype wire

// File: rtl/payload_safety_interlock_top.sv
// Top level: config registers, input register, interlock core, result register.
// The input register feeds the result register; a result is valid once its item moves from one to the other.
// Throughput: one item per cycle while the result side takes one per cycle.
// The input register frees as its item moves to the result register.
// Reset (synchronous, active low): mode idle, core counters and stored values zero,
// limits back to 1000 ticks, 50 dm, 50 dm/s; both stages empty.
`timescale 1ns / 1ps
`default_nettype none
module payload_safety_interlock_top (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_cfg_we,
    input  wire logic [psi_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  wire logic [psi_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  wire logic                                 i_in_valid,
    output var  logic                                 o_in_ready,
    input  wire logic [psi_pkg::FUNC_W-1:0]           i_func,
    input  wire logic signed [psi_pkg::ALT_W-1:0]     i_altitude_dm,
    input  wire logic [psi_pkg::WIND_W-1:0]           i_wind_dmps,
    output var  logic                                 o_out_valid,
    input  wire logic                                 i_out_ready,
    output var  logic [psi_pkg::MODE_W-1:0]           o_mode,
    output var  logic                                 o_pump_on,
    output var  logic                                 o_cargo_released,
    output var  logic                                 o_inhibit_event,
    output var  logic [psi_pkg::REASON_W-1:0]         o_breach_reason,
    output var  logic [psi_pkg::COUNT_W-1:0]          o_pulse_total
);

    psi_pkg::t_cfg                     r_cfg;
    logic                              r_in_valid;
    logic [psi_pkg::FUNC_W-1:0]        r_func;
    logic signed [psi_pkg::ALT_W-1:0]  r_alt;
    logic [psi_pkg::WIND_W-1:0]        r_wind;
    logic                              r_out_valid;
    psi_pkg::t_result                  r_result, n_result;
    logic                              advance;
    logic                              in_xfer;

    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;
    assign in_xfer    = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.link_timeout_ticks <= psi_pkg::LINK_TIMEOUT_RST;
            r_cfg.max_altitude_dm    <= psi_pkg::MAX_ALTITUDE_RST;
            r_cfg.max_wind_dmps      <= psi_pkg::MAX_WIND_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                psi_pkg::CFG_LINK_TIMEOUT: r_cfg.link_timeout_ticks <= i_cfg_data;
                psi_pkg::CFG_MAX_ALTITUDE:
                    r_cfg.max_altitude_dm <= i_cfg_data[psi_pkg::MAXALT_W-1:0];
                psi_pkg::CFG_MAX_WIND:
                    r_cfg.max_wind_dmps <= i_cfg_data[psi_pkg::WIND_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_func <= i_func;
            r_alt  <= i_altitude_dm;
            r_wind <= i_wind_dmps;
        end
    end

    psi_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_advance     (advance),
        .i_func        (r_func),
        .i_altitude_dm (r_alt),
        .i_wind_dmps   (r_wind),
        .i_cfg         (r_cfg),
        .o_result      (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_mode           = r_result.mode;
    assign o_pump_on        = r_result.pump_on;
    assign o_cargo_released = r_result.cargo_released;
    assign o_inhibit_event  = r_result.inhibit_event;
    assign o_breach_reason  = r_result.breach_reason;
    assign o_pulse_total    = r_result.pulse_total;

endmodule
`default_nettype wire
